// ===== src/luhn_card_number_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Luhn classifier assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_MACROS_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define LUHN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LUHN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// Luhn classifier package
// Widths, brand codes and the result record shared by the classifier files.
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int CARD_W    = 63;
  localparam int DIGITS    = 19;
  localparam int BCD_W     = 4 * DIGITS;
  localparam int BIT_CNT_W = $clog2(CARD_W);
  localparam int POS_W     = 5;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(CARD_W - 1);
  localparam logic [POS_W-1:0]     LAST_POS  = POS_W'(DIGITS);
  localparam logic [POS_W-1:0]     MAX_COUNT = POS_W'(DIGITS);

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_AMEX   = 2'd1,
    KIND_MASTER = 2'd2,
    KIND_VISA   = 2'd3
  } card_kind_e;

  typedef struct packed {
    card_kind_e       kind;
    logic             ok;
    logic [POS_W-1:0] count;
    logic [7:0]       sum;
    logic [6:0]       pair;
    logic [3:0]       lead;
  } luhn_result_t;

endpackage

// ===== src/luhn_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// Luhn binary to BCD converter
// Shift-and-add-3 conversion, one input bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module luhn_bcd_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [luhn_pkg::CARD_W-1:0]       bin_i,
  output logic                              done_o,
  output logic [luhn_pkg::BCD_W-1:0]        bcd_o
);
  import luhn_pkg::*;

  logic [CARD_W-1:0]    bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  // per-digit correction before each shift
  always_comb begin
    logic [3:0] dig;
    dig = '0;
    for (int i = 0; i < DIGITS; i++) begin
      dig = bcd_q[4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[CARD_W-1]};
      bin_d = {bin_q[CARD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== src/luhn_digit_scan.sv =====
// ----------------------------------------------------------------------------
// Luhn digit scanner
// Walks the BCD digits LSB first, one per cycle; builds sum, count, leading
// digits and the brand.
// ----------------------------------------------------------------------------
module luhn_digit_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [luhn_pkg::BCD_W-1:0]    bcd_i,
  output logic                          done_o,
  output luhn_pkg::luhn_result_t        result_o
);
  import luhn_pkg::*;

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [3:0]       mod_q, mod_d;
  logic [3:0]       lead_q, lead_d;
  logic [3:0]       prev_q, prev_d;
  logic [6:0]       pair_q, pair_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [3:0] dig;
  logic [4:0] dbl;
  logic [4:0] fold;
  logic [3:0] wgt;
  logic [4:0] mod_sum;
  logic [6:0] pair_out;
  logic [3:0] lead_out;
  logic       ok;

  assign dig     = bcd_q[3:0];
  assign dbl     = {dig, 1'b0};
  assign fold    = (dbl >= 5'd10) ? dbl - 5'd9 : dbl;
  // even positions (from 1 at the LSB end) are doubled
  assign wgt     = pos_q[0] ? dig : fold[3:0];
  assign mod_sum = {1'b0, mod_q} + {1'b0, wgt};

  always_comb begin
    bcd_d   = bcd_q;
    pos_d   = pos_q;
    count_d = count_q;
    sum_d   = sum_q;
    mod_d   = mod_q;
    lead_d  = lead_q;
    prev_d  = prev_q;
    pair_d  = pair_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      bcd_d   = bcd_i;
      pos_d   = POS_W'(1);
      count_d = '0;
      sum_d   = '0;
      mod_d   = '0;
      lead_d  = '0;
      prev_d  = '0;
      pair_d  = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {4'b0000, bcd_q[BCD_W-1:4]};
      sum_d  = sum_q + {4'b0000, wgt};
      mod_d  = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
      prev_d = dig;
      if (dig != 4'd0) begin
        // latest nonzero digit is the most significant one so far
        count_d = pos_q;
        lead_d  = dig;
        pair_d  = ({3'b000, dig} << 3) + ({3'b000, dig} << 1) + {3'b000, prev_q};
      end
      pos_d = pos_q + 1'b1;
      if (pos_q == LAST_POS) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    count_q <= count_d;
    sum_q   <= sum_d;
    mod_q   <= mod_d;
    lead_q  <= lead_d;
    prev_q  <= prev_d;
    pair_q  <= pair_d;
  end

  assign ok       = (mod_q == 4'd0);
  assign lead_out = (count_q >= POS_W'(2)) ? lead_q : 4'd0;
  assign pair_out = (count_q >= POS_W'(3)) ? pair_q : 7'd0;

  always_comb begin
    result_o.kind  = KIND_NONE;
    result_o.ok    = ok;
    result_o.count = count_q;
    result_o.sum   = sum_q;
    result_o.pair  = pair_out;
    result_o.lead  = lead_out;
    if (!ok) begin
      result_o.kind = KIND_NONE;
    end else if (count_q == POS_W'(15) && (pair_out == 7'd34 || pair_out == 7'd37)) begin
      result_o.kind = KIND_AMEX;
    end else if (count_q == POS_W'(16) && pair_out >= 7'd51 && pair_out <= 7'd55) begin
      result_o.kind = KIND_MASTER;
    end else if ((count_q == POS_W'(13) || count_q == POS_W'(16)) && lead_out == 4'd4) begin
      result_o.kind = KIND_VISA;
    end
  end

  assign done_o = done_q;

endmodule

// ===== src/luhn_card_number_classifier.sv =====
// ----------------------------------------------------------------------------
// Luhn card number classifier
// Path: input transaction -> bit-serial BCD converter -> digit scan -> handoff to the output register.
// Flow: one transaction at a time; the input stalls until the result is handed to the output register.
// Reset: rst_ni async active low; clears the sequencer and output valid; datapath not reset.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [luhn_pkg::CARD_W-1:0]   card_number_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    card_kind_o,
  output logic                          checksum_ok_o,
  output logic [4:0]                    digit_count_o,
  output logic [7:0]                    digit_sum_o,
  output logic [6:0]                    leading_pair_o,
  output logic [3:0]                    leading_digit_o
);
  import luhn_pkg::*;

  `include "luhn_card_number_classifier_macros.svh"

  // Sequencer: idle -> convert (binary to BCD) -> scan digits -> hand the
  // result to the output register. The output register parts the two
  // channels: a new transaction is taken while a result still waits.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]   state_q, state_d;
  logic         in_accept;
  logic         conv_done;
  logic [BCD_W-1:0] bcd;
  logic         scan_start;
  logic         scan_done;
  luhn_result_t scan_res;
  logic         load_out;
  logic         out_valid_q, out_valid_d;
  luhn_result_t out_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Bit-serial conversion, MSB first.
  luhn_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .bin_i   (card_number_i),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  assign scan_start = (state_q == ST_CONV) && conv_done;

  // Digit scan, LSB first, one decimal digit per cycle.
  luhn_digit_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .bcd_i    (bcd),
    .done_o   (scan_done),
    .result_o (scan_res)
  );

  // Scan result stays stable until the next start, so WAIT may hold it
  // for as long as the output side stalls.
  assign load_out = (state_q == ST_WAIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= scan_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign card_kind_o     = out_q.kind;
  assign checksum_ok_o   = out_q.ok;
  assign digit_count_o   = out_q.count;
  assign digit_sum_o     = out_q.sum;
  assign leading_pair_o  = out_q.pair;
  assign leading_digit_o = out_q.lead;

  `LUHN_ASSERT_NOW(a_conv_done_in_conv, conv_done, state_q == ST_CONV, "conv done outside CONV")
  `LUHN_ASSERT_NOW(a_scan_done_in_scan, scan_done, state_q == ST_SCAN, "scan done outside SCAN")
  `LUHN_ASSERT_NXT(a_accept_starts_conv, in_accept, state_q == ST_CONV, "accept did not start conv")
  `LUHN_ASSERT_NOW(a_kind_needs_ok, out_valid_q && out_q.kind != KIND_NONE, out_q.ok, "brand on bad checksum")
  `LUHN_ASSERT_NOW(a_count_range, out_valid_q, out_q.count <= MAX_COUNT, "digit count out of range")

endmodule
